// ===== hw/rtl/qtse_pkg.sv =====
package qtse_pkg;

    localparam int FRAC    = 16;
    localparam int COORD_W = 17;
    localparam int OUT_W   = 24;
    localparam int NODES   = 15;
    localparam int TERMS   = 15;
    localparam int DTERMS  = 10;
    localparam int NODE_W  = 4;
    localparam int COEF_W  = 13;
    localparam int MONO_W  = 4 * COORD_W;
    localparam int ACC_W   = 88;
    localparam int V_W     = ACC_W - 3 * FRAC;
    localparam int U_W     = OUT_W + 2;
    localparam int RCP_W   = 32;
    localparam int RCP_SH  = 33;

    localparam int MODE_VAL = 0;
    localparam int MODE_DR  = 1;
    localparam int MODE_DS  = 2;

    localparam logic [NODE_W-1:0] LAST_NODE = NODE_W'(NODES - 1);

    typedef logic [MONO_W-1:0]        t_mono;
    typedef logic signed [ACC_W-1:0]  t_acc;
    typedef logic signed [V_W-1:0]    t_val;
    typedef logic signed [COEF_W-1:0] t_coef;
    typedef logic [OUT_W-1:0]         t_res;

    typedef struct packed {
        logic              valid;
        logic [NODE_W-1:0] node;
    } t_tag;

    localparam t_acc RND_BIAS = t_acc'(3) <<< (3 * FRAC - 1);
    localparam t_val CL_HI    = t_val'(3 * (2 ** (OUT_W - 1)) - 1);
    localparam t_val CL_LO    = t_val'(-3 * (2 ** (OUT_W - 1)));
    localparam t_val CL_OFS   = t_val'(3 * (2 ** (OUT_W - 1)));
    localparam logic [U_W-1:0]   U_MAX  = U_W'(6 * (2 ** (OUT_W - 1)) - 1);
    localparam logic [RCP_W-1:0] RECIP3 = 32'hAAAAAAAB;

    localparam int EXP_R [TERMS] = '{0,1,0,2,1,0,3,2,1,0,4,3,2,1,0};
    localparam int EXP_S [TERMS] = '{0,0,1,0,1,2,0,1,2,3,0,1,2,3,4};

    // Three times each monomial coefficient, one row per node.
    localparam int COEF3 [NODES][TERMS] = '{
        '{   3, -25, -25,   70,  140,   70,  -80, -240, -240,  -80,   32,  128,  192,  128,   32 },
        '{   0,  48,   0, -208, -208,    0,  288,  576,  288,    0, -128, -384, -384, -128,    0 },
        '{   0, -36,   0,  228,   84,    0, -384, -432,  -48,    0,  192,  384,  192,    0,    0 },
        '{   0,  16,   0, -112,  -16,    0,  224,   96,    0,    0, -128, -128,    0,    0,    0 },
        '{   0,  -3,   0,   22,    0,    0,  -48,    0,    0,    0,   32,    0,    0,    0,    0 },
        '{   0,   0,  48,    0, -208, -208,    0,  288,  576,  288,    0, -128, -384, -384, -128 },
        '{   0,   0,   0,    0,  288,    0,    0, -672, -672,    0,    0,  384,  768,  384,    0 },
        '{   0,   0,   0,    0,  -96,    0,    0,  480,   96,    0,    0, -384, -384,    0,    0 },
        '{   0,   0,   0,    0,   16,    0,    0,  -96,    0,    0,    0,  128,    0,    0,    0 },
        '{   0,   0, -36,    0,   84,  228,    0,  -48, -432, -384,    0,    0,  192,  384,  192 },
        '{   0,   0,   0,    0,  -96,    0,    0,   96,  480,    0,    0,    0, -384, -384,    0 },
        '{   0,   0,   0,    0,   12,    0,    0,  -48,  -48,    0,    0,    0,  192,    0,    0 },
        '{   0,   0,  16,    0,  -16, -112,    0,    0,   96,  224,    0,    0,    0, -128, -128 },
        '{   0,   0,   0,    0,   16,    0,    0,    0,  -96,    0,    0,    0,    0,  128,    0 },
        '{   0,   0,  -3,    0,    0,   22,    0,    0,    0,  -48,    0,    0,    0,    0,   32 }
    };

    function automatic int mono_idx(input int a, input int b);
        int d;
        d = a + b;
        return ((d * (d + 1)) >> 1) + b;
    endfunction

    // Coefficient of scaled monomial j in the value or in one derivative.
    // A derivative of a degree-d monomial lands on the degree d-1 monomial,
    // so derivatives use only the first DTERMS monomials.
    function automatic t_coef term_coef(input logic [NODE_W-1:0] node, input int mode,
                                        input int j);
        int a;
        int b;
        int c;
        a = EXP_R[j];
        b = EXP_S[j];
        c = 0;
        if (int'(node) < NODES) begin
            if (mode == MODE_VAL) begin
                c = COEF3[node][j];
            end else if (j < DTERMS) begin
                if (mode == MODE_DR) begin
                    c = COEF3[node][mono_idx(a + 1, b)] * (a + 1);
                end else begin
                    c = COEF3[node][mono_idx(a, b + 1)] * (b + 1);
                end
            end
        end
        return t_coef'(c);
    endfunction

endpackage

// ===== hw/rtl/qtse_front.sv =====
module qtse_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_valid,
    input  logic [qtse_pkg::COORD_W-1:0] i_coord_r,
    input  logic [qtse_pkg::COORD_W-1:0] i_coord_s,
    output logic                         o_ready,
    output qtse_pkg::t_tag               o_tag,
    output qtse_pkg::t_mono              o_mono [qtse_pkg::TERMS]
);

    localparam int CW = qtse_pkg::COORD_W;
    localparam int F  = qtse_pkg::FRAC;

    logic                r_v0;
    logic [CW-1:0]       r_r;
    logic [CW-1:0]       r_s;
    logic [2*CW-1:0]     r_r2;
    logic [2*CW-1:0]     r_rs;
    logic [2*CW-1:0]     r_s2;
    logic                r_v1;
    logic [qtse_pkg::NODE_W-1:0] r_node;
    qtse_pkg::t_mono     r_mono [qtse_pkg::TERMS];
    qtse_pkg::t_mono     n_mono [qtse_pkg::TERMS];

    logic [3*CW-1:0] w_r3, w_r2s, w_rs2, w_s3;
    logic [4*CW-1:0] w_r4, w_r3s, w_r2s2, w_rs3, w_s4;
    logic            w_fe;

    // The held coordinate pair is released once its last node is issued.
    assign w_fe    = i_en && (!r_v1 || (r_node == qtse_pkg::LAST_NODE));
    assign o_ready = w_fe || (i_en && !r_v0);

    assign w_r3   = r_r2 * r_r;
    assign w_r2s  = r_r2 * r_s;
    assign w_rs2  = r_rs * r_s;
    assign w_s3   = r_s2 * r_s;
    assign w_r4   = r_r2 * r_r2;
    assign w_r3s  = r_r2 * r_rs;
    assign w_r2s2 = r_r2 * r_s2;
    assign w_rs3  = r_rs * r_s2;
    assign w_s4   = r_s2 * r_s2;

    // Every monomial is scaled to 4F fraction bits.
    always_comb begin
        n_mono[0]  = qtse_pkg::t_mono'(1) << (4 * F);
        n_mono[1]  = qtse_pkg::t_mono'(r_r) << (3 * F);
        n_mono[2]  = qtse_pkg::t_mono'(r_s) << (3 * F);
        n_mono[3]  = qtse_pkg::t_mono'(r_r2) << (2 * F);
        n_mono[4]  = qtse_pkg::t_mono'(r_rs) << (2 * F);
        n_mono[5]  = qtse_pkg::t_mono'(r_s2) << (2 * F);
        n_mono[6]  = qtse_pkg::t_mono'(w_r3) << F;
        n_mono[7]  = qtse_pkg::t_mono'(w_r2s) << F;
        n_mono[8]  = qtse_pkg::t_mono'(w_rs2) << F;
        n_mono[9]  = qtse_pkg::t_mono'(w_s3) << F;
        n_mono[10] = qtse_pkg::t_mono'(w_r4);
        n_mono[11] = qtse_pkg::t_mono'(w_r3s);
        n_mono[12] = qtse_pkg::t_mono'(w_r2s2);
        n_mono[13] = qtse_pkg::t_mono'(w_rs3);
        n_mono[14] = qtse_pkg::t_mono'(w_s4);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0   <= 1'b0;
            r_v1   <= 1'b0;
            r_node <= '0;
        end else begin
            if (o_ready) begin
                r_v0 <= i_valid;
            end
            if (w_fe) begin
                r_v1   <= r_v0;
                r_node <= '0;
            end else if (i_en && r_v1) begin
                r_node <= r_node + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_r  <= i_coord_r;
            r_s  <= i_coord_s;
            r_r2 <= i_coord_r * i_coord_r;
            r_rs <= i_coord_r * i_coord_s;
            r_s2 <= i_coord_s * i_coord_s;
        end
        if (w_fe) begin
            r_mono <= n_mono;
        end
    end

    assign o_tag.valid = r_v1;
    assign o_tag.node  = r_node;
    assign o_mono      = r_mono;

endmodule

// ===== hw/rtl/qtse_accum.sv =====
module qtse_accum (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  qtse_pkg::t_tag  i_tag,
    input  qtse_pkg::t_mono i_mono [qtse_pkg::TERMS],
    output qtse_pkg::t_tag  o_tag,
    output qtse_pkg::t_acc  o_sum [3]
);

    localparam int LANES = 16;

    qtse_pkg::t_acc n_p  [3][LANES];
    qtse_pkg::t_acc r_p  [3][LANES];
    qtse_pkg::t_acc r_l1 [3][LANES/2];
    qtse_pkg::t_acc r_l2 [3][LANES/4];
    qtse_pkg::t_acc r_l3 [3][LANES/8];
    qtse_pkg::t_acc r_sum[3];
    qtse_pkg::t_tag r_tag[5];

    // One product per monomial and output: value, d/dr, d/ds.
    always_comb begin
        for (int o = 0; o < 3; o++) begin
            for (int j = 0; j < qtse_pkg::TERMS; j++) begin
                n_p[o][j] = qtse_pkg::t_acc'(qtse_pkg::term_coef(i_tag.node, o, j))
                            * qtse_pkg::t_acc'($signed({1'b0, i_mono[j]}));
            end
            n_p[o][LANES-1] = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 5; k++) begin
                r_tag[k] <= '0;
            end
        end else if (i_en) begin
            r_tag[0] <= i_tag;
            for (int k = 1; k < 5; k++) begin
                r_tag[k] <= r_tag[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= n_p;
            for (int o = 0; o < 3; o++) begin
                for (int i = 0; i < LANES/2; i++) begin
                    r_l1[o][i] <= r_p[o][2*i] + r_p[o][2*i+1];
                end
                for (int i = 0; i < LANES/4; i++) begin
                    r_l2[o][i] <= r_l1[o][2*i] + r_l1[o][2*i+1];
                end
                for (int i = 0; i < LANES/8; i++) begin
                    r_l3[o][i] <= r_l2[o][2*i] + r_l2[o][2*i+1];
                end
                r_sum[o] <= r_l3[o][0] + r_l3[o][1];
            end
        end
    end

    assign o_tag = r_tag[4];
    assign o_sum = r_sum;

endmodule

// ===== hw/rtl/qtse_round.sv =====
module qtse_round (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  qtse_pkg::t_tag i_tag,
    input  qtse_pkg::t_acc i_sum [3],
    output qtse_pkg::t_tag o_tag,
    output qtse_pkg::t_res o_res [3]
);

    localparam int F   = qtse_pkg::FRAC;
    localparam int OW  = qtse_pkg::OUT_W;
    localparam int UW  = qtse_pkg::U_W;
    localparam int PW  = qtse_pkg::U_W + qtse_pkg::RCP_W;

    qtse_pkg::t_tag r_tag[4];
    qtse_pkg::t_val r_v  [3];
    logic [UW-1:0]  r_u  [3];
    logic [PW-1:0]  r_prod[3];
    qtse_pkg::t_res r_res[3];
    qtse_pkg::t_acc w_b  [3];
    qtse_pkg::t_val w_o  [3];
    logic [UW-1:0]  n_u  [3];
    logic [OW-1:0]  w_f  [3];

    // Clamping before the divide by three is exact because floor is monotonic.
    always_comb begin
        for (int o = 0; o < 3; o++) begin
            w_b[o] = i_sum[o] + qtse_pkg::RND_BIAS;
            w_o[o] = r_v[o] + qtse_pkg::CL_OFS;
            if (r_v[o] > qtse_pkg::CL_HI) begin
                n_u[o] = qtse_pkg::U_MAX;
            end else if (r_v[o] < qtse_pkg::CL_LO) begin
                n_u[o] = '0;
            end else begin
                n_u[o] = w_o[o][UW-1:0];
            end
            w_f[o] = r_prod[o][qtse_pkg::RCP_SH +: OW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 4; k++) begin
                r_tag[k] <= '0;
            end
        end else if (i_en) begin
            r_tag[0] <= i_tag;
            for (int k = 1; k < 4; k++) begin
                r_tag[k] <= r_tag[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int o = 0; o < 3; o++) begin
                r_v[o]    <= w_b[o][qtse_pkg::ACC_W-1:3*F];
                r_u[o]    <= n_u[o];
                r_prod[o] <= PW'(r_u[o]) * PW'(qtse_pkg::RECIP3);
                // The quotient is offset by half the output range; flipping
                // its top bit removes the offset.
                r_res[o]  <= {~w_f[o][OW-1], w_f[o][OW-2:0]};
            end
        end
    end

    assign o_tag = r_tag[3];
    assign o_res = r_res;

endmodule

// ===== hw/rtl/quartic_triangle_shape_eval_top.sv =====
// Quartic 15-node triangle shape function evaluator. Each input beat carries one
// natural coordinate pair (r, s) in unsigned Q1.16 and yields fifteen output beats,
// nodes 0 to 14 in order, each holding the shape value and its r and s derivatives
// in signed Q7.16, rounded to nearest (ties upward) and saturated; tlast marks node 14.
// The single node slot issues one node per cycle into the pipeline while the output is not
// stalled, and results stream one per cycle under that condition. A new pair is accepted
// while the previous pair is still issuing its nodes. No state is kept between pairs, and
// a stall on the output holds the whole pipeline.
module quartic_triangle_shape_eval_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [39:0] i_s_tdata,  // coord_r[16:0], coord_s[33:17], zero pad
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [79:0] o_m_tdata,  // node_index[3:0], shape_value[27:4],
                                    // deriv_r[51:28], deriv_s[75:52], zero pad
    output logic        o_m_tlast
);

    localparam int CW = qtse_pkg::COORD_W;

    logic            w_en;
    qtse_pkg::t_tag  w_tag_f;
    qtse_pkg::t_tag  w_tag_a;
    qtse_pkg::t_tag  w_tag_o;
    qtse_pkg::t_mono w_mono [qtse_pkg::TERMS];
    qtse_pkg::t_acc  w_sum  [3];
    qtse_pkg::t_res  w_res  [3];

    assign w_en = !w_tag_o.valid || i_m_tready;

    qtse_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (w_en),
        .i_valid   (i_s_tvalid),
        .i_coord_r (i_s_tdata[CW-1:0]),
        .i_coord_s (i_s_tdata[2*CW-1:CW]),
        .o_ready   (o_s_tready),
        .o_tag     (w_tag_f),
        .o_mono    (w_mono)
    );

    qtse_accum u_accum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_tag   (w_tag_f),
        .i_mono  (w_mono),
        .o_tag   (w_tag_a),
        .o_sum   (w_sum)
    );

    qtse_round u_round (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_tag   (w_tag_a),
        .i_sum   (w_sum),
        .o_tag   (w_tag_o),
        .o_res   (w_res)
    );

    assign o_m_tvalid = w_tag_o.valid;
    assign o_m_tdata  = {4'b0000, w_res[2], w_res[1], w_res[0], w_tag_o.node};
    assign o_m_tlast  = (w_tag_o.node == qtse_pkg::LAST_NODE);

endmodule

// ===== tb/quartic_triangle_shape_eval_top_tb.sv =====
module quartic_triangle_shape_eval_top_tb;

    localparam int CYCLE_LIMIT  = 2000000;
    localparam int RANDOM_ITEMS = 350;
    localparam int ONE          = 65536;
    localparam int CW           = qtse_pkg::COORD_W;
    localparam int OW           = qtse_pkg::OUT_W;
    localparam int NW           = qtse_pkg::NODE_W;
    localparam int SAT_HI       = (1 << (OW - 1)) - 1;
    localparam int SAT_LO       = -(1 << (OW - 1));

    typedef struct {
        logic [NW-1:0]        node;
        logic signed [OW-1:0] value;
        logic signed [OW-1:0] d_r;
        logic signed [OW-1:0] d_s;
        logic                 last;
    } t_node_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [39:0] i_s_tdata;   // coord_r[16:0], coord_s[33:17], zero pad
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [79:0] o_m_tdata;   // node_index[3:0], shape_value[27:4],
                              // deriv_r[51:28], deriv_s[75:52], zero pad
    logic        o_m_tlast;

    t_node_result pending_nodes[$];
    int           mismatch_count;
    int           cycle_count;
    bit           hold_request;

    quartic_triangle_shape_eval_top u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Exact sum of three-times coefficients, scaled to 4*FRAC fraction bits,
    // then rounded to FRAC bits with ties upward, floor-divided by 3 and clamped.
    function automatic logic signed [OW-1:0] shape_poly(input int node, input int mode,
                                                        input logic [CW-1:0] r,
                                                        input logic [CW-1:0] s);
        logic signed [127:0] acc;
        logic signed [127:0] term;
        logic signed [127:0] quot;
        logic signed [127:0] r_w;
        logic signed [127:0] s_w;
        int a;
        int b;
        int c;
        acc = '0;
        r_w = {111'b0, r};
        s_w = {111'b0, s};
        for (int k = 0; k < qtse_pkg::TERMS; k++) begin
            c = qtse_pkg::COEF3[node][k];
            a = qtse_pkg::EXP_R[k];
            b = qtse_pkg::EXP_S[k];
            if (mode == qtse_pkg::MODE_DR) begin
                c = c * a;
                a = a - 1;
            end else if (mode == qtse_pkg::MODE_DS) begin
                c = c * b;
                b = b - 1;
            end
            if (c != 0) begin
                term = 128'(c);
                for (int e = 0; e < a; e++) term = term * r_w;
                for (int e = 0; e < b; e++) term = term * s_w;
                term = term <<< (qtse_pkg::FRAC * (4 - a - b));
                acc = acc + term;
            end
        end
        acc = acc + (128'sd3 <<< (3 * qtse_pkg::FRAC - 1));
        acc = acc >>> (3 * qtse_pkg::FRAC);
        quot = acc / 128'sd3;
        if ((acc % 128'sd3) != 0 && acc < 0) quot = quot - 128'sd1;
        if (quot > 128'(SAT_HI)) quot = 128'(SAT_HI);
        if (quot < 128'(SAT_LO)) quot = 128'(SAT_LO);
        return quot[OW-1:0];
    endfunction

    task automatic queue_shape_set(input logic [CW-1:0] r, input logic [CW-1:0] s);
        t_node_result nr;
        for (int n = 0; n < qtse_pkg::NODES; n++) begin
            nr.node  = NW'(n);
            nr.value = shape_poly(n, qtse_pkg::MODE_VAL, r, s);
            nr.d_r   = shape_poly(n, qtse_pkg::MODE_DR, r, s);
            nr.d_s   = shape_poly(n, qtse_pkg::MODE_DS, r, s);
            nr.last  = (n == qtse_pkg::NODES - 1);
            pending_nodes.push_back(nr);
        end
    endtask

    task automatic send_coord(input logic [CW-1:0] r, input logic [CW-1:0] s);
        int gap;
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {6'b0, s, r};
        do @(posedge i_clk); while (!o_s_tready);
        queue_shape_set(r, s);
        gap = ($urandom_range(0, 9) < 6) ? 0 :
              (($urandom_range(0, 9) < 8) ? $urandom_range(1, 4) : $urandom_range(10, 60));
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_in_triangle();
        int r;
        r = $urandom_range(0, ONE);
        send_coord(CW'(r), CW'($urandom_range(0, ONE - r)));
    endtask

    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        while (pending_nodes.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_corners();
        send_coord(CW'(0), CW'(0));
        send_coord(CW'(ONE), CW'(0));
        send_coord(CW'(0), CW'(ONE));
        send_coord(CW'(ONE / 2), CW'(ONE / 2));
        send_coord(CW'(ONE / 3), CW'(ONE / 3));
        send_coord(17'h1FFFF, 17'h1FFFF);
        send_coord(17'h1FFFF, CW'(0));
        send_coord(CW'(0), 17'h1FFFF);
        send_coord(CW'(ONE), CW'(ONE));
        send_coord(17'h15555, 17'h0AAAA);
        send_coord(17'h0AAAA, 17'h15555);
    endtask

    // Interior and edge nodes sit on the quarter grid of the triangle.
    task automatic test_grid_nodes();
        for (int i = 0; i <= 4; i++) begin
            for (int j = 0; i + j <= 4; j += 2) begin
                send_coord(CW'(i * ONE / 4), CW'(j * ONE / 4));
            end
        end
    endtask

    task automatic test_output_stall();
        hold_request = 1'b1;
        for (int i = 0; i < 8; i++) send_in_triangle();
        wait_drained();
    endtask

    task automatic test_random();
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if ($urandom_range(0, 9) < 8) begin
                send_in_triangle();
            end else begin
                send_coord(CW'($urandom), CW'($urandom));
            end
            if (i == RANDOM_ITEMS / 2) wait_drained();
        end
    endtask

    initial begin
        int stall;
        i_m_tready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                i_m_tready <= 1'b0;
                repeat (400) @(posedge i_clk);
            end
            if (stall > 0) begin
                stall--;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= 1'b1;
                if ($urandom_range(0, 99) < 15) begin
                    stall = ($urandom_range(0, 9) < 9) ? $urandom_range(1, 3)
                                                       : $urandom_range(15, 50);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        t_node_result exp_nr;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_nodes.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) $display("unexpected beat: %h", o_m_tdata);
            end else begin
                exp_nr = pending_nodes.pop_front();
                if (o_m_tdata[3:0] !== exp_nr.node || o_m_tdata[27:4] !== exp_nr.value ||
                    o_m_tdata[51:28] !== exp_nr.d_r || o_m_tdata[75:52] !== exp_nr.d_s ||
                    o_m_tlast !== exp_nr.last) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("mismatch: exp node %0d N %h dr %h ds %h last %b",
                                 exp_nr.node, exp_nr.value, exp_nr.d_r, exp_nr.d_s,
                                 exp_nr.last);
                        $display("          got node %0d N %h dr %h ds %h last %b",
                                 o_m_tdata[3:0], o_m_tdata[27:4], o_m_tdata[51:28],
                                 o_m_tdata[75:52], o_m_tlast);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        mismatch_count = 0;
        cycle_count    = 0;
        hold_request   = 1'b0;
        i_rst_n        = 1'b0;
        i_s_tvalid     = 1'b0;
        i_s_tdata      = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_corners();
        test_grid_nodes();
        test_output_stall();
        test_random();
        i_s_tvalid <= 1'b0;
        wait_drained();
        repeat (40) @(posedge i_clk);
        if (mismatch_count == 0 && pending_nodes.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
